// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the element ALU.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/fpea_pkg.sv -----
// Types and constants of the element ALU.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package fpea_pkg;

    localparam int DATA_W  = 64;
    localparam int HALF_W  = 32;
    localparam int MODE_W  = 3;
    localparam int SHIFT_W = 6;

    // fold constants for the two Fermat primes
    localparam int FOLD8_SH  = 8;
    localparam int FOLD16_SH = 16;
    localparam logic [DATA_W-1:0] RES_257   = 64'd256;
    localparam logic [DATA_W-1:0] RES_65537 = 64'd65536;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADDSUB    = 3'd0,
        MODE_MULADD    = 3'd1,
        MODE_MUL       = 3'd2,
        MODE_LSHIFT    = 3'd3,
        MODE_FOLD256   = 3'd4,
        MODE_MOD257    = 3'd5,
        MODE_FOLD65536 = 3'd6,
        MODE_MOD65537  = 3'd7
    } mode_t;

endpackage
`default_nettype wire

// ----- rtl/fpea_in_if.sv -----
// Operand channel of the element ALU: valid/ready plus one operand word.
// Depends on fpea_pkg for field widths.
`default_nettype none
interface fpea_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [fpea_pkg::MODE_W-1:0]     mode;
    logic signed [fpea_pkg::DATA_W-1:0]     first_operand;
    logic signed [fpea_pkg::DATA_W-1:0]     second_operand;
    logic signed [fpea_pkg::DATA_W-1:0]     third_operand;
    logic        [fpea_pkg::SHIFT_W-1:0]    shift_amount;

    modport source (
        output valid, mode, first_operand, second_operand, third_operand, shift_amount,
        input  ready
    );
    modport sink (
        input  valid, mode, first_operand, second_operand, third_operand, shift_amount,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/fpea_out_if.sv -----
// Result channel of the element ALU: valid/ready plus one result word.
// Depends on fpea_pkg for field widths.
`default_nettype none
interface fpea_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fpea_pkg::DATA_W-1:0] result_primary;
    logic signed [fpea_pkg::DATA_W-1:0] result_secondary;

    modport source (
        output valid, result_primary, result_secondary,
        input  ready
    );
    modport sink (
        input  valid, result_primary, result_secondary,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/fermat_prime_element_alu.sv -----
// Top level of the element ALU: four-stage pipeline for NTT coefficient arithmetic.
// Depends on fpea_pkg, fpea_in_if, fpea_out_if and assert_macros.svh.
//
// Usage:
//  - request carries one operand word per handshake: mode, operands a, b, c and
//    a shift distance. response carries one result word for every operand word.
//  - A word passes through the stage 1 to stage 4 registers and leaves on
//    response in order. Throughput is one word per cycle with response.ready
//    held high.
//  - Stage 1 forms the three 32x32 partial products, the sum and difference,
//    the shift and the first folds; stage 2 adds the cross products; stage 3
//    adds the accumulator; folds for mod 257 (two per stage) and mod 65537
//    (one per stage) run across all four stages. The 32x32 multipliers set
//    the depth of stage 1.
//  - Stage 4 is the output register. When response.ready is low, the words
//    in flight close up any bubbles and then hold; request.ready drops only
//    once all four stages are full. Nothing is lost or repeated.
//  - Reset (rst_n low, asynchronous) clears the valid bits; the block keeps no
//    other state, so request.ready is high as soon as the valid bits are clear.
//  - result_secondary is a-b in add-subtract mode and zero otherwise.
`default_nettype none
`include "assert_macros.svh"
module fermat_prime_element_alu (
    input  logic       clk,
    input  logic       rst_n,
    fpea_in_if.sink    request,
    fpea_out_if.source response
);

    localparam int DW = fpea_pkg::DATA_W;
    localparam int HW = fpea_pkg::HALF_W;

    typedef struct packed {
        fpea_pkg::mode_t mode;
        logic [DW-1:0]   val;   // running value or accumulator addend
        logic [DW-1:0]   aux;   // product under construction
        logic [DW-1:0]   sec;   // secondary result
    } stage_t;

    // (v & 255) - (v >>> 8)
    function automatic logic [DW-1:0] fold_256(input logic [DW-1:0] v);
        return {{(DW-fpea_pkg::FOLD8_SH){1'b0}}, v[fpea_pkg::FOLD8_SH-1:0]}
             - {{fpea_pkg::FOLD8_SH{v[DW-1]}}, v[DW-1:fpea_pkg::FOLD8_SH]};
    endfunction

    // (v & 65535) - (v >>> 16)
    function automatic logic [DW-1:0] fold_65536(input logic [DW-1:0] v);
        return {{(DW-fpea_pkg::FOLD16_SH){1'b0}}, v[fpea_pkg::FOLD16_SH-1:0]}
             - {{fpea_pkg::FOLD16_SH{v[DW-1]}}, v[DW-1:fpea_pkg::FOLD16_SH]};
    endfunction

    // handshake chain: a stage moves when it is empty or its successor moves
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    stage_t s1_next, s2_next, s3_next, s4_next;
    stage_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [HW-1:0] pp_lh_reg, pp_hl_reg;

    // stage 1 datapath signals
    fpea_pkg::mode_t mode_in;
    logic [DW-1:0]   op_a, op_b, op_c;
    logic [DW-1:0]   mul_x, mul_y;
    logic [DW-1:0]   pp_ll;
    logic [HW-1:0]   pp_lh, pp_hl;
    logic [HW-1:0]   cross_sum;
    logic [DW-1:0]   s4_val;

    assign adv4 = response.ready || !v4_reg;
    assign adv3 = adv4 || !v3_reg;
    assign adv2 = adv3 || !v2_reg;
    assign adv1 = adv2 || !v1_reg;
    assign request.ready = adv1;

    // ---------------- stage 1 ----------------
    assign mode_in = fpea_pkg::mode_t'(request.mode);
    assign op_a    = request.first_operand;
    assign op_b    = request.second_operand;
    assign op_c    = request.third_operand;

    // mul: a*b; muladd: b*c with a as addend
    assign mul_x = (mode_in == fpea_pkg::MODE_MUL) ? op_a : op_b;
    assign mul_y = (mode_in == fpea_pkg::MODE_MUL) ? op_b : op_c;

    // low 64 bits of x*y need lo*lo in full and only the low half of the cross terms
    assign pp_ll = DW'(mul_x[HW-1:0]) * DW'(mul_y[HW-1:0]);
    assign pp_lh = mul_x[HW-1:0] * mul_y[DW-1:HW];
    assign pp_hl = mul_x[DW-1:HW] * mul_y[HW-1:0];

    always_comb
    begin
        s1_next      = '0;
        s1_next.mode = mode_in;
        s1_next.aux  = pp_ll;
        unique case (mode_in)
            fpea_pkg::MODE_ADDSUB:
            begin
                s1_next.val = op_a + op_b;
                s1_next.sec = op_a - op_b;
            end
            fpea_pkg::MODE_MULADD:    s1_next.val = op_a;
            fpea_pkg::MODE_MUL:       s1_next.val = '0;
            fpea_pkg::MODE_LSHIFT:    s1_next.val = op_a << request.shift_amount;
            fpea_pkg::MODE_FOLD256:   s1_next.val = fold_256(op_a);
            fpea_pkg::MODE_MOD257:    s1_next.val = fold_256(fold_256(op_a));
            fpea_pkg::MODE_FOLD65536: s1_next.val = fold_65536(op_a);
            fpea_pkg::MODE_MOD65537:  s1_next.val = fold_65536(op_a);
            default:                  s1_next.val = '0;
        endcase
    end

    // ---------------- stage 2 ----------------
    assign cross_sum = pp_lh_reg + pp_hl_reg;

    always_comb
    begin
        s2_next = s1_reg;
        unique case (s1_reg.mode) inside
            fpea_pkg::MODE_MOD257:   s2_next.val = fold_256(fold_256(s1_reg.val));
            fpea_pkg::MODE_MOD65537: s2_next.val = fold_65536(s1_reg.val);
            fpea_pkg::MODE_MUL, fpea_pkg::MODE_MULADD:
                s2_next.aux = s1_reg.aux + {cross_sum, {HW{1'b0}}};
            default: ;
        endcase
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        s3_next = s2_reg;
        unique case (s2_reg.mode) inside
            fpea_pkg::MODE_MOD257:   s3_next.val = fold_256(fold_256(s2_reg.val));
            fpea_pkg::MODE_MOD65537: s3_next.val = fold_65536(s2_reg.val);
            fpea_pkg::MODE_MUL, fpea_pkg::MODE_MULADD:
                s3_next.val = s2_reg.val + s2_reg.aux;
            default: ;
        endcase
    end

    // ---------------- stage 4: last folds, -1 maps to p-1 ----------------
    always_comb
    begin
        s4_next = s3_reg;
        s4_val  = s3_reg.val;
        unique case (s3_reg.mode) inside
            fpea_pkg::MODE_MOD257:
            begin
                s4_val      = fold_256(fold_256(s3_reg.val));
                s4_next.val = (s4_val == '1) ? fpea_pkg::RES_257 : s4_val;
            end
            fpea_pkg::MODE_MOD65537:
            begin
                s4_val      = fold_65536(s3_reg.val);
                s4_next.val = (s4_val == '1) ? fpea_pkg::RES_65537 : s4_val;
            end
            default: ;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= request.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg    <= s1_next;
            pp_lh_reg <= pp_lh;
            pp_hl_reg <= pp_hl;
        end
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
        if (adv4) s4_reg <= s4_next;
    end

    assign response.valid            = v4_reg;
    assign response.result_primary   = s4_reg.val;
    assign response.result_secondary = s4_reg.sec;

    // ---------------- checks ----------------
    `ASSERT_CLKD(a_accept_lands, clk, rst_n,
        (request.valid && request.ready) |=> v1_reg)
    `ASSERT_CLKD(a_stall_keeps, clk, rst_n,
        (v3_reg && !adv4) |=> (v3_reg && v4_reg))
    `ASSERT_NEVER(a_sec_zero, clk, rst_n,
        v4_reg && (s4_reg.mode != fpea_pkg::MODE_ADDSUB) && (s4_reg.sec != '0))
    `ASSERT_NEVER(a_full_ready, clk, rst_n,
        request.ready && v1_reg && v2_reg && v3_reg && v4_reg && !response.ready)

endmodule
`default_nettype wire
